// ===== rtl/redundant_copy_eliminator_macros.svh =====
// ----------------------------------------------------------------------------
// redundant_copy_eliminator macros
// Assertion wrappers for the copy eliminator; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef REDUNDANT_COPY_ELIMINATOR_MACROS_SVH
`define REDUNDANT_COPY_ELIMINATOR_MACROS_SVH

`ifndef SYNTHESIS
`define RCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCE_ASSERT_SAME(lbl, ante, cons, msg)
`define RCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants of the redundant copy eliminator.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_INDEX_BITS    = 16;
  localparam int DEF_TAG_BITS      = 32;

  localparam int TAG_W   = 32;
  localparam int INDEX_W = 16;
  localparam int SLOT_W  = 8;

  typedef enum logic [1:0] {
    KIND_OTHER    = 2'd0,
    KIND_ACCESSOR = 2'd1,
    KIND_READ     = 2'd2,
    KIND_WRITE    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [TAG_W-1:0]   buffer_tag;
    logic [INDEX_W-1:0] command_index;
  } cmd_t;

  typedef struct packed {
    logic               keep_this;
    logic               cancel_valid;
    logic [INDEX_W-1:0] cancel_index;
    logic               table_overflow;
  } res_t;

  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic               hit;
    logic               keep;
    logic               cancel_valid;
    logic [INDEX_W-1:0] cancel_index;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
  } token_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [INDEX_W-1:0] index;
    logic               is_read;
  } alloc_t;

endpackage

// ===== rtl/rce_cell.sv =====
// ----------------------------------------------------------------------------
// rce_cell
// One table entry; checks the passing item and hands it to the next cell.
// ----------------------------------------------------------------------------
module rce_cell #(
  parameter int SLOT     = 0,
  parameter int TAG_KEEP = rce_pkg::TAG_W,
  parameter int IDX_KEEP = rce_pkg::INDEX_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rce_pkg::alloc_t alloc,
  input  rce_pkg::token_t tok_in,
  output rce_pkg::token_t tok_out
);

  localparam logic [rce_pkg::SLOT_W-1:0] MY_SLOT = rce_pkg::SLOT_W'(SLOT);

  logic                used;
  logic                pending;
  logic                write_seen;
  logic [TAG_KEEP-1:0] tag;
  logic [IDX_KEEP-1:0] index;
  logic                hit;
  logic                alloc_here;
  rce_pkg::token_t     tok_next;
  rce_pkg::token_t     tok;

  assign hit = tok_in.valid && used && (tok_in.cmd.kind != rce_pkg::KIND_OTHER)
               && (tag == tok_in.cmd.buffer_tag[TAG_KEEP-1:0]);
  assign alloc_here = alloc.en && (alloc.slot == MY_SLOT);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.hit = 1'b1;
      unique case (tok_in.cmd.kind)
        rce_pkg::KIND_READ: begin
          if (pending) begin
            tok_next.cancel_valid = 1'b1;
            tok_next.cancel_index = rce_pkg::INDEX_W'(index);
          end
        end
        rce_pkg::KIND_WRITE: begin
          tok_next.keep = !write_seen;
        end
        rce_pkg::KIND_ACCESSOR, rce_pkg::KIND_OTHER: begin
        end
      endcase
    end else if (tok_in.valid && !used && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_slot  = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= 1'b0;
      pending    <= 1'b0;
      write_seen <= 1'b0;
    end else if (alloc_here) begin
      used       <= 1'b1;
      pending    <= alloc.is_read;
      write_seen <= !alloc.is_read;
    end else if (advance && hit) begin
      unique case (tok_in.cmd.kind)
        rce_pkg::KIND_ACCESSOR: begin
          used       <= 1'b0;
          pending    <= 1'b0;
          write_seen <= 1'b0;
        end
        rce_pkg::KIND_READ:  pending    <= 1'b1;
        rce_pkg::KIND_WRITE: write_seen <= 1'b1;
        rce_pkg::KIND_OTHER: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_here) begin
      tag <= alloc.tag[TAG_KEEP-1:0];
    end
    if (alloc_here && alloc.is_read) begin
      index <= alloc.index[IDX_KEEP-1:0];
    end else if (advance && hit && tok_in.cmd.kind == rce_pkg::KIND_READ) begin
      index <= tok_in.cmd.command_index[IDX_KEEP-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (advance) begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

// ===== rtl/redundant_copy_eliminator.sv =====
// ----------------------------------------------------------------------------
// redundant_copy_eliminator
// Drops redundant read and write copies in a stream of transfer commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one command item: kind,
//   buffer tag and sequence index. res channel (res_valid/res_ready/res)
//   returns exactly one result item per command: keep flag, cancelled
//   earlier read index and table overflow flag.
//   Each entry of the buffer table is a cell in a chain; an item walks the
//   chain one cell per cycle while the chain is not held, and a missing buffer
//   is given the lowest free cell once the item leaves the last cell.
//   One item is in flight at a time: a new command is accepted only once the
//   previous item has left the last cell of the chain.
//   A finished result waits in the output register while the next item is
//   accepted. If the receiver stalls with a result still waiting, the item
//   that reaches the chain end holds there until the register frees.
//   Reset empties the table and drops any item in flight.
// ----------------------------------------------------------------------------
`include "redundant_copy_eliminator_macros.svh"

module redundant_copy_eliminator #(
  parameter int TABLE_ENTRIES = rce_pkg::DEF_TABLE_ENTRIES,
  parameter int INDEX_BITS    = rce_pkg::DEF_INDEX_BITS,
  parameter int TAG_BITS      = rce_pkg::DEF_TAG_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rce_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output rce_pkg::res_t res
);

  localparam int TAG_KEEP = (TAG_BITS < rce_pkg::TAG_W) ? TAG_BITS : rce_pkg::TAG_W;
  localparam int IDX_KEEP = (INDEX_BITS < rce_pkg::INDEX_W) ? INDEX_BITS : rce_pkg::INDEX_W;

  rce_pkg::token_t          tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] tok_valid;
  rce_pkg::token_t          last;
  rce_pkg::alloc_t          alloc;
  rce_pkg::res_t            res_next;
  rce_pkg::res_t            res_q;
  logic                     busy;
  logic                     advance;
  logic                     fire_last;
  logic                     needs_entry;

  assign cmd_ready = !rst && !busy;

  always_comb begin
    tok[0]              = '0;
    tok[0].valid        = cmd_valid && cmd_ready;
    tok[0].cmd          = cmd;
    tok[0].keep         = 1'b1;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rce_cell #(
      .SLOT     (i),
      .TAG_KEEP (TAG_KEEP),
      .IDX_KEEP (IDX_KEEP)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .alloc   (alloc),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  assign last        = tok[TABLE_ENTRIES];
  assign advance     = !(last.valid && res_valid && !res_ready);
  assign fire_last   = last.valid && advance;
  assign needs_entry = (last.cmd.kind == rce_pkg::KIND_READ ||
                        last.cmd.kind == rce_pkg::KIND_WRITE) && !last.hit;

  always_comb begin
    alloc         = '0;
    alloc.en      = fire_last && needs_entry && last.free_found;
    alloc.slot    = last.free_slot;
    alloc.tag     = last.cmd.buffer_tag;
    alloc.index   = last.cmd.command_index;
    alloc.is_read = (last.cmd.kind == rce_pkg::KIND_READ);
  end

  always_comb begin
    res_next                = '0;
    res_next.keep_this      = last.keep;
    res_next.cancel_valid   = last.cancel_valid;
    res_next.cancel_index   = last.cancel_index;
    if (needs_entry) begin
      res_next.keep_this      = 1'b1;
      res_next.cancel_valid   = 1'b0;
      res_next.cancel_index   = '0;
      res_next.table_overflow = !last.free_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        busy <= 1'b1;
      end else if (fire_last) begin
        busy <= 1'b0;
      end
      if (fire_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      res_q <= res_next;
    end
  end

  assign res = res_q;

  `RCE_ASSERT_SAME(a_one_in_flight, 1'b1, $onehot0(tok_valid), "more than one item in chain")
  `RCE_ASSERT_NEXT(a_result_loaded, fire_last, res_valid, "result lost at chain end")
  `RCE_ASSERT_SAME(a_ovf_kept, res_valid && res.table_overflow,
                   res.keep_this && !res.cancel_valid, "overflow item not kept")
  `RCE_ASSERT_SAME(a_busy_chain, tok_valid != '0, busy, "item in chain while idle")

endmodule

// ===== test/copy_elim_check_pkg.sv =====
// ----------------------------------------------------------------------------
// copy_elim_check_pkg
// Scoreboard for the redundant copy eliminator: mirrors the buffer table,
// predicts the verdict of every accepted command and checks the results
// returned by the block in order.
// ----------------------------------------------------------------------------
package copy_elim_check_pkg;

  localparam int TABLE_ENTRIES = rce_pkg::DEF_TABLE_ENTRIES;
  localparam logic [rce_pkg::TAG_W-1:0] TAG_MASK =
    rce_pkg::TAG_W'((64'd1 << rce_pkg::DEF_TAG_BITS) - 64'd1);
  localparam logic [rce_pkg::INDEX_W-1:0] INDEX_MASK =
    rce_pkg::INDEX_W'((64'd1 << rce_pkg::DEF_INDEX_BITS) - 64'd1);
  localparam int REPORT_LIMIT = 10;

  class copy_elim_scoreboard;

    bit                          slot_used [TABLE_ENTRIES];
    logic [rce_pkg::TAG_W-1:0]   slot_tag [TABLE_ENTRIES];
    bit                          read_pending [TABLE_ENTRIES];
    logic [rce_pkg::INDEX_W-1:0] read_index [TABLE_ENTRIES];
    bit                          write_seen [TABLE_ENTRIES];
    rce_pkg::res_t               expected_verdicts [$];
    int                          mismatches = 0;

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_command(rce_pkg::cmd_t c);
      rce_pkg::res_t               v;
      int                          slot;
      logic [rce_pkg::TAG_W-1:0]   tag;
      logic [rce_pkg::INDEX_W-1:0] idx;
      v = '0;
      v.keep_this = 1'b1;
      tag = c.buffer_tag & TAG_MASK;
      idx = c.command_index & INDEX_MASK;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot < 0 && slot_used[i] && slot_tag[i] == tag) slot = i;
      end
      case (c.kind)
        rce_pkg::KIND_ACCESSOR: begin
          if (slot >= 0) begin
            slot_used[slot] = 1'b0;
            read_pending[slot] = 1'b0;
            write_seen[slot] = 1'b0;
          end
        end
        rce_pkg::KIND_READ, rce_pkg::KIND_WRITE: begin
          if (slot < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (slot < 0 && !slot_used[i]) begin
                slot = i;
                slot_used[i] = 1'b1;
                slot_tag[i] = tag;
                read_pending[i] = 1'b0;
                write_seen[i] = 1'b0;
              end
            end
          end
          if (slot < 0) begin
            v.table_overflow = 1'b1;
          end else if (c.kind == rce_pkg::KIND_READ) begin
            if (read_pending[slot]) begin
              v.cancel_valid = 1'b1;
              v.cancel_index = read_index[slot];
            end
            read_pending[slot] = 1'b1;
            read_index[slot] = idx;
          end else if (write_seen[slot]) begin
            v.keep_this = 1'b0;
          end else begin
            write_seen[slot] = 1'b1;
          end
        end
        default: ;
      endcase
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_result(rce_pkg::res_t r);
      rce_pkg::res_t e;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result item: keep=%0d cancel=%0d/%0h ovf=%0d",
                   r.keep_this, r.cancel_valid, r.cancel_index, r.table_overflow);
        return;
      end
      e = expected_verdicts.pop_front();
      if (r.keep_this !== e.keep_this || r.cancel_valid !== e.cancel_valid ||
          r.cancel_index !== e.cancel_index || r.table_overflow !== e.table_overflow) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result mismatch: expected keep=%0d cancel=%0d/%0h ovf=%0d,",
                    " got keep=%0d cancel=%0d/%0h ovf=%0d"},
                   e.keep_this, e.cancel_valid, e.cancel_index, e.table_overflow,
                   r.keep_this, r.cancel_valid, r.cancel_index, r.table_overflow);
      end
    endfunction

  endclass

endpackage

// ===== test/tb_redundant_copy_eliminator.sv =====
// ----------------------------------------------------------------------------
// tb_redundant_copy_eliminator
// Drives directed and random transfer commands into the copy eliminator with
// bursty input and a stalling receiver, and checks every result item against
// the scoreboard's prediction of the buffer table.
// ----------------------------------------------------------------------------
module tb_redundant_copy_eliminator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_SIZE  = 24;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  rce_pkg::cmd_t cmd       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  rce_pkg::res_t res;

  int          burst_left  = 0;
  int          stall_left  = 0;
  int unsigned rx_tick     = 0;
  int          idle_cycles = 0;

  logic [rce_pkg::TAG_W-1:0] tag_pool [POOL_SIZE];

  copy_elim_check_pkg::copy_elim_scoreboard board = new;

  always #10 clk = ~clk;

  redundant_copy_eliminator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) board.note_command(cmd);
      if (res_valid && res_ready) board.check_result(res);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (stall_left != 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_tick[9] && $urandom_range(0, 11) == 0) begin
      res_ready <= 1'b0;
      stall_left <= $urandom_range(1, 40);
    end else begin
      res_ready <= 1'b1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic rce_pkg::cmd_t make_cmd(rce_pkg::kind_e k,
                                             logic [rce_pkg::TAG_W-1:0] tag,
                                             logic [rce_pkg::INDEX_W-1:0] idx);
    rce_pkg::cmd_t c;
    c.kind = k;
    c.buffer_tag = tag;
    c.command_index = idx;
    return c;
  endfunction

  task automatic push_command(input rce_pkg::cmd_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 6);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    burst_left--;
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic issue_random_commands(input int count);
    rce_pkg::cmd_t c;
    int            pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      c.command_index = rce_pkg::INDEX_W'($urandom_range(0, 16'hFFFF));
      c.buffer_tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 8) begin
        c.kind = $urandom_range(0, 1) ? rce_pkg::KIND_OTHER : rce_pkg::KIND_ACCESSOR;
        c.buffer_tag = $urandom;
      end else if (pick < 20) c.kind = rce_pkg::KIND_OTHER;
      else if (pick < 40) c.kind = rce_pkg::KIND_ACCESSOR;
      else if (pick < 72) c.kind = rce_pkg::KIND_READ;
      else c.kind = rce_pkg::KIND_WRITE;
      push_command(c);
    end
  endtask

  initial begin
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 16; i++) tag_pool[i] = 32'h1 << (i - 1);
    for (int i = 16; i < POOL_SIZE; i++) tag_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_command(make_cmd(rce_pkg::KIND_OTHER, '1, '1));
    push_command(make_cmd(rce_pkg::KIND_ACCESSOR, '0, '0));
    push_command(make_cmd(rce_pkg::KIND_READ, '0, '0));
    push_command(make_cmd(rce_pkg::KIND_READ, '0, '1));
    push_command(make_cmd(rce_pkg::KIND_WRITE, '0, 16'h0001));
    push_command(make_cmd(rce_pkg::KIND_WRITE, '0, 16'h0002));
    push_command(make_cmd(rce_pkg::KIND_ACCESSOR, '0, 16'h0003));
    push_command(make_cmd(rce_pkg::KIND_READ, '0, 16'h0004));
    for (int i = 0; i < 15; i++)
      push_command(make_cmd(rce_pkg::KIND_WRITE, (i == 0) ? '1 : 32'h1 << i,
                            16'h8000 >> i));
    push_command(make_cmd(rce_pkg::KIND_READ, 32'hA5A5_5A5A, 16'h1234));
    push_command(make_cmd(rce_pkg::KIND_WRITE, 32'hA5A5_5A5A, 16'h5678));
    push_command(make_cmd(rce_pkg::KIND_ACCESSOR, '1, 16'h9ABC));
    push_command(make_cmd(rce_pkg::KIND_READ, '1, 16'hFFFE));
    drain_results();

    issue_random_commands(500);
    drain_results();
    issue_random_commands(500);
    drain_results();
    issue_random_commands(500);
    drain_results();

    repeat (copy_elim_check_pkg::TABLE_ENTRIES + 5) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
